// ----- rtl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned TASKS_DEF   = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TSLOT_W = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RESULTS);

  // input tdata layout, lowest bit first
  localparam int unsigned SLOT_LSB   = CMD_W;
  localparam int unsigned EN_BIT     = SLOT_LSB + SLOT_W;
  localparam int unsigned PERIOD_LSB = EN_BIT + 1;
  localparam int unsigned NOW_LSB    = PERIOD_LSB + TIME_W;
  localparam int unsigned IN_USED_W  = NOW_LSB + TIME_W;
  localparam int unsigned IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout: status, task_slot
  localparam int unsigned OUT_USED_W = 1 + TSLOT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_DEL = 3'd1,
    CMD_EN  = 3'd2,
    CMD_DIS = 3'd3,
    CMD_UPD = 3'd4,
    CMD_RUN = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_UPD,
    ST_RUN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic idx_inc;
    logic rd_en;
    logic found_set;
    logic commit;
    logic run_fire;
    logic run_last;
  } ctrl_t;

  typedef struct packed {
    cmd_e new_cmd;
    logic period_zero;
    logic cur_free;
    logic cur_fire;
    logic fire_above;
    logic idx_last;
    logic cnt_last;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/periodic_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler_core
// Periodic task scheduler: slot table with add, delete, enable, disable,
// update and run commands.
// ----------------------------------------------------------------------------
//  port group   dir  content
//  s_axis_*     in   command transaction: cmd, slot, start_enabled, period, now
//  m_axis_*     out  result transaction: status, task_slot; tuser fired; tlast last
//
//  Delete, enable, disable and unknown commands go straight to the response.
//  Add: free-slot scan, one slot a cycle, to the first free slot or the last one;
//  a zero period skips it. Update: every slot in turn, one memory read a cycle;
//  run: one slot a cycle, with a final response only when no slot fires.
//  Reset clears all slot marks; the result register decouples output stalls,
//  which hold the slot walk of run only when a result is waiting.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_core #(
  parameter int unsigned TASKS = pts_pkg::TASKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cmd[2:0], slot[10:3], start_enabled[11], period[43:12], now[75:44], zero pad
  input  logic [pts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[0], task_slot[4:1], zero pad
  output logic [pts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // fired[0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  pts_pkg::ctrl_t ctrl;
  pts_pkg::stat_t stat;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pts_dp #(
    .TASKS (TASKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_fired_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = ctrl.in_ready;

endmodule

// ----- rtl/pts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pts_ctrl
// Command sequencer: accepts a transaction, walks the slot table and issues
// result commands to the datapath.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  pts_pkg::stat_t stat_i,
  output pts_pkg::ctrl_t ctrl_o
);

  pts_pkg::state_e state_q, state_d;
  logic            fire_last;

  assign fire_last = stat_i.cnt_last | ~stat_i.fire_above;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.new_cmd)
            pts_pkg::CMD_ADD: state_d = pts_pkg::ST_ADD;
            pts_pkg::CMD_UPD: state_d = pts_pkg::ST_UPD;
            pts_pkg::CMD_RUN: state_d = pts_pkg::ST_RUN;
            default:          state_d = pts_pkg::ST_RESP;
          endcase
        end
      end
      pts_pkg::ST_ADD: begin
        if (stat_i.period_zero || stat_i.cur_free || stat_i.idx_last) begin
          state_d = pts_pkg::ST_RESP;
        end
      end
      pts_pkg::ST_UPD: begin
        if (stat_i.idx_last) begin
          state_d = pts_pkg::ST_RESP;
        end
      end
      pts_pkg::ST_RUN: begin
        if (stat_i.cur_fire) begin
          if (stat_i.out_free && fire_last) begin
            state_d = pts_pkg::ST_IDLE;
          end
        end else if (stat_i.idx_last) begin
          state_d = pts_pkg::ST_RESP;
        end
      end
      pts_pkg::ST_RESP: begin
        if (stat_i.out_free) begin
          state_d = pts_pkg::ST_IDLE;
        end
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.load     = in_valid_i;
      end
      pts_pkg::ST_ADD: begin
        if (!stat_i.period_zero) begin
          if (stat_i.cur_free) begin
            ctrl_o.found_set = 1'b1;
          end else begin
            ctrl_o.idx_inc = ~stat_i.idx_last;
          end
        end
      end
      pts_pkg::ST_UPD: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.idx_inc = ~stat_i.idx_last;
      end
      pts_pkg::ST_RUN: begin
        if (stat_i.cur_fire) begin
          if (stat_i.out_free) begin
            ctrl_o.run_fire = 1'b1;
            ctrl_o.run_last = fire_last;
            ctrl_o.idx_inc  = ~fire_last & ~stat_i.idx_last;
          end
        end else begin
          ctrl_o.idx_inc = ~stat_i.idx_last;
        end
      end
      pts_pkg::ST_RESP: begin
        ctrl_o.commit = stat_i.out_free;
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule

// ----- rtl/pts_dp.sv -----
// ----------------------------------------------------------------------------
// pts_dp
// Scheduler datapath: slot flags, interval and last-run memories, command
// registers, walk counters and the result register.
// ----------------------------------------------------------------------------
module pts_dp #(
  parameter int unsigned TASKS = pts_pkg::TASKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pts_pkg::ctrl_t                  ctrl_i,
  output pts_pkg::stat_t                  stat_o,
  input  logic [pts_pkg::IN_DATA_W-1:0]   in_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [pts_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic                            out_fired_o,
  output logic                            out_last_o
);

  localparam int unsigned IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  pts_pkg::cmd_e                    cmd_q;
  logic [pts_pkg::SLOT_W-1:0]       slot_q;
  logic                             start_en_q;
  logic [pts_pkg::TIME_W-1:0]       period_q;
  logic [pts_pkg::TIME_W-1:0]       now_q;

  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [pts_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                             found_q, found_d;
  logic                             rd_vld_q;
  logic [IDX_W-1:0]                 rd_idx_q;

  logic [TASKS-1:0]                 occ_q, occ_d;
  logic [TASKS-1:0]                 en_q, en_d;
  logic [TASKS-1:0]                 due_q, due_d;
  logic [TASKS-1:0]                 fire_vec;
  logic [TASKS-1:0]                 above_vec;

  logic [pts_pkg::TIME_W-1:0]       int_mem  [TASKS];
  logic [pts_pkg::TIME_W-1:0]       last_mem [TASKS];
  logic [pts_pkg::TIME_W-1:0]       int_rd_q;
  logic [pts_pkg::TIME_W-1:0]       last_rd_q;
  logic [pts_pkg::TIME_W-1:0]       elapsed;

  logic                             slot_ok;
  logic [IDX_W-1:0]                 slot_idx;
  logic                             add_wr;
  logic                             res_status;
  logic [pts_pkg::TSLOT_W-1:0]      res_slot;

  logic                             out_vld_q;
  logic                             out_status_q;
  logic [pts_pkg::TSLOT_W-1:0]      out_slot_q;
  logic                             out_fired_q;
  logic                             out_last_q;

  // command capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q      <= pts_pkg::cmd_e'(in_data_i[pts_pkg::CMD_W-1:0]);
      slot_q     <= in_data_i[pts_pkg::SLOT_LSB +: pts_pkg::SLOT_W];
      start_en_q <= in_data_i[pts_pkg::EN_BIT];
      period_q   <= in_data_i[pts_pkg::PERIOD_LSB +: pts_pkg::TIME_W];
      now_q      <= in_data_i[pts_pkg::NOW_LSB +: pts_pkg::TIME_W];
    end
  end

  assign slot_ok  = slot_q < pts_pkg::SLOT_W'(TASKS);
  assign slot_idx = slot_q[IDX_W-1:0];
  assign add_wr   = ctrl_i.commit && (cmd_q == pts_pkg::CMD_ADD) && found_q;

  // walk counters
  always_comb begin
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    if (ctrl_i.load) begin
      idx_d   = '0;
      cnt_d   = '0;
      found_d = 1'b0;
    end else begin
      if (ctrl_i.idx_inc) begin
        idx_d = idx_q + 1'b1;
      end
      if (ctrl_i.run_fire) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (ctrl_i.found_set) begin
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      rd_vld_q <= ctrl_i.rd_en;
      rd_idx_q <= idx_q;
    end
  end

  // interval and last-run stores; occupied mark qualifies every read
  always_ff @(posedge clk_i) begin
    if (add_wr) begin
      int_mem[idx_q] <= period_q;
    end
    if (add_wr || ctrl_i.run_fire) begin
      last_mem[idx_q] <= now_q;
    end
    if (ctrl_i.rd_en) begin
      int_rd_q  <= int_mem[idx_q];
      last_rd_q <= last_mem[idx_q];
    end
  end

  assign elapsed = now_q - last_rd_q;

  // slot flags
  always_comb begin
    occ_d = occ_q;
    en_d  = en_q;
    due_d = due_q;
    if (rd_vld_q && occ_q[rd_idx_q] && en_q[rd_idx_q] && (elapsed >= int_rd_q)) begin
      due_d[rd_idx_q] = 1'b1;
    end
    if (ctrl_i.run_fire) begin
      due_d[idx_q] = 1'b0;
    end
    if (ctrl_i.commit) begin
      unique case (cmd_q)
        pts_pkg::CMD_ADD: begin
          if (found_q) begin
            occ_d[idx_q] = 1'b1;
            en_d[idx_q]  = start_en_q;
            due_d[idx_q] = 1'b0;
          end
        end
        pts_pkg::CMD_DEL: begin
          if (slot_ok) begin
            occ_d[slot_idx] = 1'b0;
            en_d[slot_idx]  = 1'b0;
            due_d[slot_idx] = 1'b0;
          end
        end
        pts_pkg::CMD_EN, pts_pkg::CMD_DIS: begin
          if (slot_ok && occ_q[slot_idx]) begin
            en_d[slot_idx] = (cmd_q == pts_pkg::CMD_EN);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      en_q  <= '0;
      due_q <= '0;
    end else begin
      occ_q <= occ_d;
      en_q  <= en_d;
      due_q <= due_d;
    end
  end

  assign fire_vec = occ_q & en_q & due_q;

  always_comb begin
    for (int j = 0; j < TASKS; j++) begin
      above_vec[j] = fire_vec[j] && (IDX_W'(j) > idx_q);
    end
  end

  // single-result outcome
  always_comb begin
    res_slot = '0;
    unique case (cmd_q)
      pts_pkg::CMD_ADD: begin
        res_status = ~found_q;
        res_slot   = found_q ? pts_pkg::TSLOT_W'(idx_q) : '0;
      end
      pts_pkg::CMD_DEL:                  res_status = ~slot_ok;
      pts_pkg::CMD_EN, pts_pkg::CMD_DIS: res_status = ~(slot_ok && occ_q[slot_idx]);
      pts_pkg::CMD_UPD, pts_pkg::CMD_RUN: res_status = 1'b0;
      default:                           res_status = 1'b1;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl_i.commit || ctrl_i.run_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_fired_q  <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (ctrl_i.run_fire) begin
      out_status_q <= 1'b0;
      out_slot_q   <= pts_pkg::TSLOT_W'(idx_q);
      out_fired_q  <= 1'b1;
      out_last_q   <= ctrl_i.run_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = pts_pkg::OUT_DATA_W'({out_slot_q, out_status_q});
  assign out_fired_o = out_fired_q;
  assign out_last_o  = out_last_q;

  assign stat_o.new_cmd     = pts_pkg::cmd_e'(in_data_i[pts_pkg::CMD_W-1:0]);
  assign stat_o.period_zero = (period_q == '0);
  assign stat_o.cur_free    = ~occ_q[idx_q];
  assign stat_o.cur_fire    = fire_vec[idx_q];
  assign stat_o.fire_above  = |above_vec;
  assign stat_o.idx_last    = (idx_q == IDX_W'(TASKS - 1));
  assign stat_o.cnt_last    = (cnt_q == pts_pkg::CNT_W'(pts_pkg::MAX_RESULTS - 1));
  assign stat_o.out_free    = ~out_vld_q | out_ready_i;

endmodule

// ----- rtl/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks for the periodic task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result transaction changed");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
    else $error("fired result carries error status");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("non-fired result is not final");

  a_err_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[4:1] == 4'd0)
    else $error("error result names a slot");

endmodule

bind periodic_task_scheduler_core pts_checker u_pts_checker (.*);
